// ===== design/tfmd_pkg.sv =====
// Shared types and constants for the target-follow mecanum drive block.
// Used by the top level and by the serial divider; no dependencies.
package tfmd_pkg;

  // Widths fixed by the register and field definitions.
  localparam int GAIN_W    = 20;
  localparam int SPEED_W   = 7;
  localparam int OFFSET_W  = 8;
  localparam int WHEEL_W   = 8;
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOST_AREA     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_APPROACH_AREA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RETREAT_AREA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECIP_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_SPIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RETREAT_SPEED = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_FORWARD   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FORWARD   = 3'd7;

  // Register reset values.
  localparam int LOST_AREA_RST     = 500;
  localparam int APPROACH_AREA_RST = 20000;
  localparam int RETREAT_AREA_RST  = 24000;
  localparam int RECIP_GAIN_RST    = 100000;
  localparam int SEARCH_SPIN_RST   = 15;
  localparam int RETREAT_SPEED_RST = 10;
  localparam int MIN_FORWARD_RST   = 5;
  localparam int MAX_FORWARD_RST   = 40;

  // Speed limit and the offset added to the approach quotient.
  localparam int SPEED_LIMIT    = 100;
  localparam int APPROACH_BIAS  = 15;

  typedef enum logic [1:0] {
    MODE_SEARCH   = 2'd0,
    MODE_APPROACH = 2'd1,
    MODE_HOLD     = 2'd2,
    MODE_RETREAT  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MIX
  } state_e;

endpackage

// ===== design/tfmd_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
// Depends on tfmd_pkg only through the common import convention.
module tfmd_div import tfmd_pkg::*; #(
  parameter int NUM_W = 20,
  parameter int DEN_W = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  // The dividend shifts out of the top of the quotient register while
  // quotient bits shift in at the bottom. A zero divisor yields all ones.
  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = (trial >= {1'b0, den_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quot_d = {quot_q[NUM_W-2:0], fits};
      rem_d  = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  a_done_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("divider restarted while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("divider done without a division in flight");

endmodule

// ===== design/target_follow_mecanum_drive_core.sv =====
// Top level of the target-follow mecanum drive block: mode selection,
// approach speed, wheel mixing and configuration. Uses tfmd_pkg and tfmd_div.
//
// Usage:
//   Each input transfer carries one camera report (offset_x_i, blob_area_i).
//   Each report yields exactly one output transfer with four saturated wheel
//   speeds, the target-seen flag and the drive mode.
//   Search, hold and retreat reports pass from the input transfer to the mix
//   state and then into the output register. Approach reports first run the
//   area through a bit-serial divider, one quotient bit per cycle over the 20
//   bits of the gain, and reach the mix state once the quotient is done.
//   The block takes one report at a time; in_ready_o rises again at the edge
//   that loads the result into the output register.
//   The output register holds a finished result while a new report is taken
//   in; if the receiver stalls, the block finishes the next report and then
//   waits with it until the output register is free. Configuration writes
//   take effect at once and must be issued while idle; the block does not
//   check this. Reset loads the default thresholds and speeds, empties the
//   output register and sets the remembered search direction to negative spin.
module target_follow_mecanum_drive_core import tfmd_pkg::*; #(
  parameter int AREA_BITS = 24
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [((AREA_BITS > GAIN_W) ? AREA_BITS : GAIN_W)-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [OFFSET_W-1:0]       offset_x_i,
  input  logic [AREA_BITS-1:0]             blob_area_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [WHEEL_W-1:0]        wheel_0_o,
  output logic signed [WHEEL_W-1:0]        wheel_1_o,
  output logic signed [WHEEL_W-1:0]        wheel_2_o,
  output logic signed [WHEEL_W-1:0]        wheel_3_o,
  output logic                             target_seen_o,
  output logic [1:0]                       drive_mode_o
);

  // Mixer sums of three terms of up to 100 in magnitude fit in 10 bits.
  localparam int MIX_W = 10;
  localparam int QSUM_W = GAIN_W + 1;

  // Configuration registers.
  logic [AREA_BITS-1:0] lost_area_q, approach_area_q, retreat_area_q;
  logic [GAIN_W-1:0]    recip_gain_q;
  logic [SPEED_W-1:0]   search_spin_q, retreat_speed_q, min_forward_q, max_forward_q;

  // Item state.
  state_e                     state_q, state_d;
  mode_e                      mode_q;
  logic                       seen_q;
  logic signed [OFFSET_W-1:0] side_q;
  logic signed [OFFSET_W-1:0] rot_q;
  logic                       last_dir_q;

  // Output register.
  logic                      out_valid_q, out_valid_d;
  logic signed [WHEEL_W-1:0] wheel0_q, wheel1_q, wheel2_q, wheel3_q;
  logic                      seen_out_q;
  logic [1:0]                mode_out_q;

  logic              in_accept;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic [GAIN_W-1:0] quot;
  mode_e             new_mode;

  logic [SPEED_W-1:0]        spin_lim, retreat_lim;
  logic signed [OFFSET_W-1:0] side_clamped;
  logic [QSUM_W-1:0]         qsum;
  logic [SPEED_W-1:0]        q_max, q_min, q_lim;
  logic signed [MIX_W-1:0]   fwd, side, rot;
  logic signed [MIX_W-1:0]   sum0, sum1, sum2, sum3;

  function automatic logic [SPEED_W-1:0] lim_speed(input logic [SPEED_W-1:0] v);
    return (v > SPEED_W'(SPEED_LIMIT)) ? SPEED_W'(SPEED_LIMIT) : v;
  endfunction

  function automatic logic signed [WHEEL_W-1:0] sat_wheel(input logic signed [MIX_W-1:0] v);
    logic signed [WHEEL_W-1:0] r;
    if (v > MIX_W'(SPEED_LIMIT)) begin
      r = WHEEL_W'(SPEED_LIMIT);
    end else if (v < -MIX_W'(SPEED_LIMIT)) begin
      r = -WHEEL_W'(SPEED_LIMIT);
    end else begin
      r = v[WHEEL_W-1:0];
    end
    return r;
  endfunction

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  // Mode selection on the incoming report.
  always_comb begin
    if (blob_area_i < lost_area_q) begin
      new_mode = MODE_SEARCH;
    end else if (blob_area_i < approach_area_q) begin
      new_mode = MODE_APPROACH;
    end else if (blob_area_i > retreat_area_q) begin
      new_mode = MODE_RETREAT;
    end else begin
      new_mode = MODE_HOLD;
    end
  end

  assign spin_lim    = lim_speed(search_spin_q);
  assign retreat_lim = lim_speed(retreat_speed_q);

  always_comb begin
    if (offset_x_i > OFFSET_W'(SPEED_LIMIT)) begin
      side_clamped = OFFSET_W'(SPEED_LIMIT);
    end else if (offset_x_i < -OFFSET_W'(SPEED_LIMIT)) begin
      side_clamped = -OFFSET_W'(SPEED_LIMIT);
    end else begin
      side_clamped = offset_x_i;
    end
  end

  assign div_start = in_accept && (new_mode == MODE_APPROACH);

  tfmd_div #(
    .NUM_W (GAIN_W),
    .DEN_W (AREA_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (recip_gain_q),
    .den_i   (blob_area_i),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // Approach speed: quotient plus bias, limited to max_forward, raised to
  // min_forward and capped at the speed limit. A zero area gives an all-ones
  // quotient, which lands on max_forward as required.
  assign qsum  = {1'b0, quot} + QSUM_W'(APPROACH_BIAS);
  assign q_max = (qsum > {{(QSUM_W-SPEED_W){1'b0}}, max_forward_q}) ?
                 max_forward_q : qsum[SPEED_W-1:0];
  assign q_min = (q_max < min_forward_q) ? min_forward_q : q_max;
  assign q_lim = lim_speed(q_min);

  // Rotation is only nonzero in search, where translation is zero, so the
  // rotation scaling of translation never changes a value.
  always_comb begin
    case (mode_q)
      MODE_APPROACH: fwd = $signed({{(MIX_W-SPEED_W){1'b0}}, q_lim});
      MODE_RETREAT:  fwd = -$signed({{(MIX_W-SPEED_W){1'b0}}, retreat_lim});
      default:       fwd = '0;
    endcase
  end

  assign side = MIX_W'(side_q);
  assign rot  = MIX_W'(rot_q);
  assign sum0 = fwd - side - rot;
  assign sum1 = fwd + side + rot;
  assign sum2 = fwd + side - rot;
  assign sum3 = fwd - side + rot;

  assign out_load = (state_q == ST_MIX) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = (new_mode == MODE_APPROACH) ? ST_DIV : ST_MIX;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        if (out_load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      out_valid_q     <= 1'b0;
      last_dir_q      <= 1'b0;
      lost_area_q     <= AREA_BITS'(LOST_AREA_RST);
      approach_area_q <= AREA_BITS'(APPROACH_AREA_RST);
      retreat_area_q  <= AREA_BITS'(RETREAT_AREA_RST);
      recip_gain_q    <= GAIN_W'(RECIP_GAIN_RST);
      search_spin_q   <= SPEED_W'(SEARCH_SPIN_RST);
      retreat_speed_q <= SPEED_W'(RETREAT_SPEED_RST);
      min_forward_q   <= SPEED_W'(MIN_FORWARD_RST);
      max_forward_q   <= SPEED_W'(MAX_FORWARD_RST);
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (in_accept && (new_mode != MODE_SEARCH)) begin
        last_dir_q <= (offset_x_i > 0);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LOST_AREA:     lost_area_q     <= cfg_wdata_i[AREA_BITS-1:0];
          REG_APPROACH_AREA: approach_area_q <= cfg_wdata_i[AREA_BITS-1:0];
          REG_RETREAT_AREA:  retreat_area_q  <= cfg_wdata_i[AREA_BITS-1:0];
          REG_RECIP_GAIN:    recip_gain_q    <= cfg_wdata_i[GAIN_W-1:0];
          REG_SEARCH_SPIN:   search_spin_q   <= cfg_wdata_i[SPEED_W-1:0];
          REG_RETREAT_SPEED: retreat_speed_q <= cfg_wdata_i[SPEED_W-1:0];
          REG_MIN_FORWARD:   min_forward_q   <= cfg_wdata_i[SPEED_W-1:0];
          REG_MAX_FORWARD:   max_forward_q   <= cfg_wdata_i[SPEED_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= new_mode;
      seen_q <= (new_mode != MODE_SEARCH);
      if (new_mode == MODE_SEARCH) begin
        side_q <= '0;
        rot_q  <= last_dir_q ? $signed({1'b0, spin_lim}) : -$signed({1'b0, spin_lim});
      end else begin
        side_q <= side_clamped;
        rot_q  <= '0;
      end
    end
    if (out_load) begin
      wheel0_q   <= sat_wheel(sum0);
      wheel1_q   <= sat_wheel(sum1);
      wheel2_q   <= sat_wheel(sum2);
      wheel3_q   <= sat_wheel(sum3);
      seen_out_q <= seen_q;
      mode_out_q <= mode_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wheel_0_o     = wheel0_q;
  assign wheel_1_o     = wheel1_q;
  assign wheel_2_o     = wheel2_q;
  assign wheel_3_o     = wheel3_q;
  assign target_seen_o = seen_out_q;
  assign drive_mode_o  = mode_out_q;

  a_div_only_approach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> mode_q == MODE_APPROACH)
    else $error("divider running for a report that is not in approach");

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("quotient finished outside the divide state");

  a_search_unseen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (drive_mode_o == MODE_SEARCH) |-> !target_seen_o)
    else $error("search result flagged as target seen");

  a_wheel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (wheel_0_o <= 8'sd100) && (wheel_0_o >= -8'sd100) &&
                    (wheel_1_o <= 8'sd100) && (wheel_1_o >= -8'sd100))
    else $error("wheel speed beyond saturation limit");

endmodule

// ===== sim/target_follow_mecanum_drive_core_tb.sv =====
// Self-checking testbench for target_follow_mecanum_drive_core: directed reports
// and randomized settings and reports, checked against a wheel-mixing predictor
// or against pinned expected commands. Depends on tfmd_pkg and the core RTL only.
module target_follow_mecanum_drive_core_tb;
  import tfmd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AREA_BITS      = 24;
  localparam int CFG_W          = (AREA_BITS > GAIN_W) ? AREA_BITS : GAIN_W;
  localparam int MAX_GAP        = 13;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 30;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_REPORTS  = 135;
  localparam int CYCLE_LIMIT    = 500000;
  localparam logic [23:0] AREA_MAX = 24'hFFFFFF;

  typedef struct {
    logic [23:0] lost_area;
    logic [23:0] approach_area;
    logic [23:0] retreat_area;
    logic [19:0] recip_gain;
    logic [6:0]  search_spin;
    logic [6:0]  retreat_speed;
    logic [6:0]  min_forward;
    logic [6:0]  max_forward;
  } drive_cfg_t;

  typedef struct {
    logic signed [7:0] w0;
    logic signed [7:0] w1;
    logic signed [7:0] w2;
    logic signed [7:0] w3;
    logic              seen;
    mode_e             mode;
  } wheel_cmd_t;

  typedef struct {
    int                setting;
    logic signed [7:0] offset;
    logic [23:0]       area;
    bit                pinned;
    wheel_cmd_t        want;
  } probe_row_t;

  localparam wheel_cmd_t NO_PIN = '{0, 0, 0, 0, 1'b0, MODE_SEARCH};

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_W-1:0]      cfg_idx_i;
  logic [CFG_W-1:0]          cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [OFFSET_W-1:0] offset_x_i;
  logic [AREA_BITS-1:0]      blob_area_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [WHEEL_W-1:0] wheel_0_o;
  logic signed [WHEEL_W-1:0] wheel_1_o;
  logic signed [WHEEL_W-1:0] wheel_2_o;
  logic signed [WHEEL_W-1:0] wheel_3_o;
  logic                      target_seen_o;
  logic [1:0]                drive_mode_o;

  target_follow_mecanum_drive_core #(.AREA_BITS(AREA_BITS)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .offset_x_i    (offset_x_i),
    .blob_area_i   (blob_area_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .wheel_0_o     (wheel_0_o),
    .wheel_1_o     (wheel_1_o),
    .wheel_2_o     (wheel_2_o),
    .wheel_3_o     (wheel_3_o),
    .target_seen_o (target_seen_o),
    .drive_mode_o  (drive_mode_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Register settings used by the directed rows; entry 0 is the reset state.
  drive_cfg_t probe_settings[5] = '{
    '{LOST_AREA_RST, APPROACH_AREA_RST, RETREAT_AREA_RST, RECIP_GAIN_RST,
      SEARCH_SPIN_RST, RETREAT_SPEED_RST, MIN_FORWARD_RST, MAX_FORWARD_RST},
    '{0, 24'hFFFFFF, 24'hFFFFFF, 20'hFFFFF, 127, 127, 127, 0},
    '{24'hFFFFFF, 0, 0, 1, 127, 0, 0, 127},
    '{1, 24'h800000, 24'h800001, 1, 0, 100, 0, 100},
    '{100, 1000, 2000, 1000, 50, 50, 60, 20}
  };

  probe_row_t probe_rows[24] = '{
    '{0, 0, 24'd0, 1'b1, '{15, -15, 15, -15, 1'b0, MODE_SEARCH}},
    '{0, 127, 24'd20000, 1'b1, '{-100, 100, 100, -100, 1'b1, MODE_HOLD}},
    '{0, -128, 24'd499, 1'b1, '{-15, 15, -15, 15, 1'b0, MODE_SEARCH}},
    '{0, -128, 24'd24001, 1'b1, '{90, -100, -100, 90, 1'b1, MODE_RETREAT}},
    '{0, 0, 24'hFFFFFF, 1'b1, '{-10, -10, -10, -10, 1'b1, MODE_RETREAT}},
    '{0, 1, 24'd500, 1'b1, '{39, 41, 41, 39, 1'b1, MODE_APPROACH}},
    '{0, 0, 24'd19999, 1'b0, NO_PIN},
    '{0, -1, 24'd24000, 1'b1, '{1, -1, -1, 1, 1'b1, MODE_HOLD}},
    '{0, 100, 24'd12345, 1'b0, NO_PIN},
    '{0, -100, 24'd499, 1'b0, NO_PIN},
    '{0, 101, 24'd3000, 1'b0, NO_PIN},
    '{1, 5, 24'd0, 1'b0, NO_PIN},
    '{1, -5, 24'hFFFFFF, 1'b1, '{5, -5, -5, 5, 1'b1, MODE_HOLD}},
    '{1, 127, 24'd1, 1'b0, NO_PIN},
    '{2, 0, 24'd0, 1'b1, '{-100, 100, -100, 100, 1'b0, MODE_SEARCH}},
    '{2, -128, 24'hFFFFFF, 1'b1, '{100, -100, -100, 100, 1'b1, MODE_RETREAT}},
    '{2, 127, 24'd1, 1'b1, '{100, -100, 100, -100, 1'b0, MODE_SEARCH}},
    '{3, 0, 24'd1, 1'b0, NO_PIN},
    '{3, 0, 24'd2, 1'b0, NO_PIN},
    '{3, 99, 24'd0, 1'b1, '{0, 0, 0, 0, 1'b0, MODE_SEARCH}},
    '{3, -128, 24'h800002, 1'b0, NO_PIN},
    '{4, 50, 24'd100, 1'b0, NO_PIN},
    '{4, -50, 24'd999, 1'b0, NO_PIN},
    '{4, 3, 24'd99, 1'b0, NO_PIN}
  };

  logic signed [7:0] offset_edges[6] = '{-128, 127, -101, 101, 100, -100};

  drive_cfg_t  cfg;
  bit          spin_right;
  wheel_cmd_t  awaited_cmds[$];
  int          mismatch_count;
  int          cycle_count;
  int          stall_requests;
  int          stall_served;
  bit          src_calm;
  bit          sink_calm;

  function automatic int clip100(input int v);
    if (v > SPEED_LIMIT) return SPEED_LIMIT;
    if (v < -SPEED_LIMIT) return -SPEED_LIMIT;
    return v;
  endfunction

  // Works out the wheel command for one report and advances the remembered
  // spin direction, which only moves when the target is seen.
  function automatic wheel_cmd_t mix_report(input logic signed [7:0] ox,
                                            input logic [23:0] area);
    wheel_cmd_t        r;
    int                side;
    int                fwd;
    int                rot;
    int                k;
    longint unsigned   q;
    side = 0;
    fwd  = 0;
    rot  = 0;
    if (area < cfg.lost_area) begin
      r.mode = MODE_SEARCH;
      r.seen = 1'b0;
      rot = spin_right ? int'(cfg.search_spin) : -int'(cfg.search_spin);
    end else begin
      r.seen = 1'b1;
      side = ox;
      if (area < cfg.approach_area) begin
        r.mode = MODE_APPROACH;
        if (area == 0) begin
          q = cfg.max_forward;
        end else begin
          q = cfg.recip_gain / area + APPROACH_BIAS;
          if (q > cfg.max_forward) q = cfg.max_forward;
        end
        if (q < cfg.min_forward) q = cfg.min_forward;
        fwd = int'(q);
      end else if (area > cfg.retreat_area) begin
        r.mode = MODE_RETREAT;
        fwd = -int'(cfg.retreat_speed);
      end else begin
        r.mode = MODE_HOLD;
      end
      spin_right = (ox > 0);
    end
    rot  = clip100(rot);
    side = clip100(side);
    fwd  = clip100(fwd);
    if (rot != 0) begin
      k = SPEED_LIMIT - (rot < 0 ? -rot : rot);
      side = side * k / SPEED_LIMIT;
      fwd  = fwd * k / SPEED_LIMIT;
    end
    r.w0 = 8'(clip100(fwd - side - rot));
    r.w1 = 8'(clip100(fwd + side + rot));
    r.w2 = 8'(clip100(fwd + side - rot));
    r.w3 = 8'(clip100(fwd - side + rot));
    return r;
  endfunction

  function automatic logic [23:0] sat_area(input longint v);
    if (v < 0) return 24'd0;
    if (v > AREA_MAX) return AREA_MAX;
    return 24'(v);
  endfunction

  function automatic logic [23:0] area_near(input longint base, input int spread);
    return sat_area(base + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic logic [23:0] area_span(input longint lo, input longint hi);
    if (hi <= lo) return sat_area(lo);
    return sat_area(lo + $urandom_range(0, 32'(hi - lo)));
  endfunction

  task automatic report_mismatch(input string field, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Unused high bits of the narrow registers carry noise; the block drops them.
  task automatic load_settings(input drive_cfg_t s);
    write_reg(REG_LOST_AREA, s.lost_area);
    write_reg(REG_APPROACH_AREA, s.approach_area);
    write_reg(REG_RETREAT_AREA, s.retreat_area);
    write_reg(REG_RECIP_GAIN, {4'($urandom), s.recip_gain});
    write_reg(REG_SEARCH_SPIN, {17'($urandom), s.search_spin});
    write_reg(REG_RETREAT_SPEED, {17'($urandom), s.retreat_speed});
    write_reg(REG_MIN_FORWARD, {17'($urandom), s.min_forward});
    write_reg(REG_MAX_FORWARD, {17'($urandom), s.max_forward});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    cfg = s;
  endtask

  task automatic send_report(input logic signed [7:0] ox, input logic [23:0] area,
                             input bit pinned, input wheel_cmd_t pin);
    int unsigned gap;
    wheel_cmd_t  cmd;
    gap = src_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    offset_x_i  <= ox;
    blob_area_i <= area;
    @(posedge clk_i);
    while (!(in_valid_i && in_ready_o)) @(posedge clk_i);
    cmd = mix_report(ox, area);
    awaited_cmds.push_back(pinned ? pin : cmd);
  endtask

  task automatic drain_reports();
    in_valid_i <= 1'b0;
    while (awaited_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    drive_cfg_t        next_cfg;
    logic signed [7:0] ox;
    logic [23:0]       area;
    int                active_setting;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = REG_LOST_AREA;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    offset_x_i     = '0;
    blob_area_i    = '0;
    cfg            = probe_settings[0];
    spin_right     = 1'b0;
    mismatch_count = 0;
    stall_requests = 0;
    src_calm       = 1'b0;
    sink_calm      = 1'b0;
    active_setting = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probe_rows[i]) begin
      if (probe_rows[i].setting != active_setting) begin
        drain_reports();
        load_settings(probe_settings[probe_rows[i].setting]);
        active_setting = probe_rows[i].setting;
      end
      send_report(probe_rows[i].offset, probe_rows[i].area, probe_rows[i].pinned,
                  probe_rows[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_reports();
      if (p == 0) begin
        next_cfg = probe_settings[0];
      end else if (p == 5) begin
        next_cfg = probe_settings[1];
      end else begin
        case ($urandom_range(0, 3))
          0:       next_cfg.lost_area = $urandom_range(0, 1000);
          1:       next_cfg.lost_area = 0;
          2:       next_cfg.lost_area = $urandom_range(0, 20000);
          default: next_cfg.lost_area = 24'($urandom);
        endcase
        next_cfg.approach_area = sat_area(next_cfg.lost_area + $urandom_range(0, 60000));
        next_cfg.retreat_area  = sat_area(next_cfg.approach_area + $urandom_range(0, 30000));
        // Now and then the thresholds come out of order.
        if ($urandom_range(0, 5) == 0) next_cfg.approach_area = 24'($urandom);
        if ($urandom_range(0, 5) == 0) next_cfg.retreat_area = 24'($urandom);
        next_cfg.recip_gain = $urandom_range(0, 1) ? 20'($urandom_range(1, 200000))
                                                   : 20'($urandom_range(1, 20'hFFFFF));
        next_cfg.search_spin   = 7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                              : $urandom_range(0, 100));
        next_cfg.retreat_speed = 7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                              : $urandom_range(0, 100));
        next_cfg.min_forward   = 7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                              : $urandom_range(0, 30));
        next_cfg.max_forward   = 7'($urandom_range(0, 3) == 0 ? $urandom_range(0, 127)
                                                              : $urandom_range(20, 100));
      end
      load_settings(next_cfg);
      src_calm  = (p % 4 == 1) || (p % 4 == 2);
      sink_calm = (p % 4 == 1) || (p % 4 == 3);
      for (int n = 0; n < PHASE_REPORTS; n++) begin
        if ((p == 2 || p == 7) && n == 20) stall_requests++;
        case ($urandom_range(0, 3))
          0:       ox = 8'($urandom);
          1:       ox = 8'(int'($urandom_range(0, 6)) - 3);
          2:       ox = offset_edges[$urandom_range(0, 5)];
          default: ox = 8'(int'($urandom_range(0, 200)) - 100);
        endcase
        case ($urandom_range(0, 9))
          0:       area = area_near(cfg.lost_area, 2);
          1:       area = area_near(cfg.approach_area, 2);
          2:       area = area_near(cfg.retreat_area, 2);
          4:       area = area_span(cfg.approach_area, cfg.retreat_area);
          5:       area = area_span(cfg.retreat_area, sat_area(cfg.retreat_area + 100000));
          6:       area = 24'($urandom);
          7:       area = $urandom_range(0, 64);
          8:       area = $urandom_range(0, 1) ? 24'd0 : AREA_MAX;
          default: area = area_span(cfg.lost_area, cfg.approach_area);
        endcase
        send_report(ox, area, 1'b0, NO_PIN);
      end
    end

    drain_reports();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Result side: random back-pressure unless sink_calm is set, plus a long
  // hold-off on request so the block backs up into its input.
  initial begin : sink
    int unsigned gap;
    out_ready_i  = 1'b0;
    stall_served = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (stall_served != stall_requests) begin
        stall_served++;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      gap = sink_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(out_valid_o && out_ready_i)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_results
    wheel_cmd_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_cmds.size() == 0) begin
        report_mismatch("unexpected result, wheel_0", wheel_0_o, 0);
      end else begin
        want = awaited_cmds.pop_front();
        if (wheel_0_o !== want.w0) report_mismatch("wheel_0", wheel_0_o, want.w0);
        if (wheel_1_o !== want.w1) report_mismatch("wheel_1", wheel_1_o, want.w1);
        if (wheel_2_o !== want.w2) report_mismatch("wheel_2", wheel_2_o, want.w2);
        if (wheel_3_o !== want.w3) report_mismatch("wheel_3", wheel_3_o, want.w3);
        if (target_seen_o !== want.seen)
          report_mismatch("target_seen", target_seen_o, want.seen);
        if (drive_mode_o !== want.mode)
          report_mismatch("drive_mode", drive_mode_o, want.mode);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/tfmd_pkg.sv
design/tfmd_div.sv
design/target_follow_mecanum_drive_core.sv
sim/target_follow_mecanum_drive_core_tb.sv
